FILE: sv/sps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

	localparam int unsigned ANGLE_STEPS = 24;
	localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [16:0] FACTOR_ONE = 17'd65536;

	localparam logic [1:0] REG_SPONGE_START = 2'd0;
	localparam logic [1:0] REG_DAMPING_RATE = 2'd1;
	localparam logic [1:0] REG_REFERENCE = 2'd2;
	localparam logic [1:0] REG_IMPLICIT = 2'd3;

	// Classified point handed from the front to the back.
	typedef struct packed {
		logic [31:0] velocity;
		logic [23:0] dz;
		logic [23:0] dt;
		logic        bad;
		logic        zero;
		logic        sat;
	} item_t;

	// Fields that ride along the back pipeline.
	typedef struct packed {
		logic [31:0] velocity;
		logic        bad;
		logic        zero;
	} meta_t;

	// atan(2^-i) in Q2.30.
	function automatic logic [31:0] angle(input int unsigned i);
		logic [31:0] a;
		case (i)
			0:  a = 32'd843314857;
			1:  a = 32'd497837829;
			2:  a = 32'd263043837;
			3:  a = 32'd133525159;
			4:  a = 32'd67021687;
			5:  a = 32'd33543516;
			6:  a = 32'd16775851;
			7:  a = 32'd8388437;
			8:  a = 32'd4194283;
			9:  a = 32'd2097149;
			10: a = 32'd1048576;
			11: a = 32'd524288;
			12: a = 32'd262144;
			13: a = 32'd131072;
			14: a = 32'd65536;
			15: a = 32'd32768;
			16: a = 32'd16384;
			17: a = 32'd8192;
			18: a = 32'd4096;
			19: a = 32'd2048;
			20: a = 32'd1024;
			21: a = 32'd512;
			22: a = 32'd256;
			23: a = 32'd128;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: sv/sps_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sps_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] point_height;
	logic [23:0] top_height;
	logic [31:0] velocity_in;
	modport source(output valid, point_height, top_height, velocity_in, input ready);
	modport sink(input valid, point_height, top_height, velocity_in, output ready);
endinterface

interface sps_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] velocity_out;
	logic [16:0] damping_factor;
	logic        bad_column;
	modport source(output valid, velocity_out, damping_factor, bad_column, input ready);
	modport sink(input valid, velocity_out, damping_factor, bad_column, output ready);
endinterface

interface sps_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/sps_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sps_front (
	input  wire             clk,
	input  wire             arst_n,
	sps_in_if.sink          point,
	input  wire [23:0]      start_height,
	output sps_pkg::item_t  item,
	output logic            item_valid,
	input  wire             item_ready
);
	logic           vld_s1;
	sps_pkg::item_t item_s1;
	logic [23:0]    dz;
	logic [23:0]    dt;
	logic           bad;

	assign point.ready = !vld_s1 || item_ready;
	assign item        = item_s1;
	assign item_valid  = vld_s1;

	assign dz  = point.point_height - start_height;
	assign dt  = point.top_height - start_height;
	assign bad = point.top_height <= start_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (point.ready) begin
			vld_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (point.ready && point.valid) begin
			item_s1.velocity <= point.velocity_in;
			item_s1.dz       <= dz;
			item_s1.dt       <= dt;
			item_s1.bad      <= bad;
			item_s1.zero     <= bad || (point.point_height <= start_height);
			item_s1.sat      <= dz >= dt;
		end
	end
endmodule
`default_nettype wire

FILE: sv/sps_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sps_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  sps_pkg::item_t  push_item,
	input  wire             push_valid,
	output logic            push_ready,
	output sps_pkg::item_t  pop_item,
	output logic            pop_valid,
	input  wire             pop_ready
);
	sps_pkg::item_t mem_q [4];
	logic [1:0]     wr_q;
	logic [1:0]     rd_q;
	logic [2:0]     count_q;
	logic           push;
	logic           pop;

	assign push_ready = count_q != 3'd4;
	assign pop_valid  = count_q != 3'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			if (push && !pop) count_q <= count_q + 3'd1;
			else if (pop && !push) count_q <= count_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= 3'd4)
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 3'd1)
		else $error("queue count did not rise on push");
	a_count_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 3'd1)
		else $error("queue count did not fall on pop");
`endif
endmodule
`default_nettype wire

FILE: sv/sps_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sps_back #(
	parameter int unsigned SINE_ITERATIONS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  sps_pkg::item_t  item,
	input  wire             item_valid,
	output logic            item_ready,
	input  wire [19:0]      rate,
	input  wire [31:0]      reference,
	input  wire             implicit_mode,
	sps_out_if.source       result
);
	localparam int unsigned N = (SINE_ITERATIONS > sps_pkg::ANGLE_STEPS) ?
		sps_pkg::ANGLE_STEPS : SINE_ITERATIONS;

	logic adv;

	// Ratio divider, one quotient bit per stage.
	logic                  dv_vld_s [0:16];
	sps_pkg::meta_t        dv_meta_s [0:16];
	logic [23:0]           dv_rem_s [0:16];
	logic [15:0]           dv_quo_s [0:16];
	logic [23:0]           dv_dt_s [0:16];
	logic                  dv_sat_s [0:16];
	logic [24:0]           dv_sh [1:16];
	logic                  dv_ge [1:16];
	logic [16:0]           dv_r;
	logic [47:0]           th_prod;

	// CORDIC rotation stages.
	logic                  c_vld_s [0:N];
	sps_pkg::meta_t        c_meta_s [0:N];
	logic signed [33:0]    c_x_s [0:N];
	logic signed [33:0]    c_y_s [0:N];
	logic signed [33:0]    c_a_s [0:N];
	logic signed [33:0]    c_xs [0:N-1];
	logic signed [33:0]    c_ys [0:N-1];
	logic signed [33:0]    c_ang [0:N-1];

	logic [30:0]           sine;
	logic                  sq_vld_s1;
	sps_pkg::meta_t        sq_meta_s1;
	logic [61:0]           sq_s1;
	logic [62:0]           f_sum;
	logic [16:0]           f_val;
	logic                  f_vld_s2;
	sps_pkg::meta_t        f_meta_s2;
	logic [16:0]           f_s2;
	logic [36:0]           g_sum;
	logic                  g_vld_s3;
	sps_pkg::meta_t        g_meta_s3;
	logic [16:0]           g_f_s3;
	logic [20:0]           g_s3;

	logic signed [32:0]    diff;
	logic [21:0]           e_d;
	logic [31:0]           e_mag;
	logic [47:0]           e_num;
	logic signed [54:0]    e_prod_s4;

	// Implicit divider, one quotient bit per stage.
	logic                  q_vld_s [0:32];
	sps_pkg::meta_t        q_meta_s [0:32];
	logic [16:0]           q_f_s [0:32];
	logic [21:0]           q_d_s [0:32];
	logic [21:0]           q_rem_s [0:32];
	logic [31:0]           q_lo_s [0:32];
	logic [31:0]           q_quo_s [0:32];
	logic [31:0]           q_res_s [1:32];
	logic [22:0]           q_sh [1:32];
	logic                  q_ge [1:32];
	logic signed [54:0]    ex_delta;
	logic signed [55:0]    ex_res;
	logic [31:0]           ex_sat;

	logic                  out_vld_q;
	logic [31:0]           out_v_q;
	logic [16:0]           out_f_q;
	logic                  out_bad_q;
	logic [31:0]           imp_res;

	assign adv        = !out_vld_q || result.ready;
	assign item_ready = adv;

	always_comb begin
		for (int k = 1; k <= 16; k++) begin
			dv_sh[k] = {dv_rem_s[k-1], 1'b0};
			dv_ge[k] = dv_sh[k] >= {1'b0, dv_dt_s[k-1]};
		end
		for (int k = 1; k <= 32; k++) begin
			q_sh[k] = {q_rem_s[k-1], q_lo_s[k-1][31]};
			q_ge[k] = q_sh[k] >= {1'b0, q_d_s[k-1]};
		end
		for (int i = 0; i < N; i++) begin
			c_xs[i]  = c_x_s[i] >>> i;
			c_ys[i]  = c_y_s[i] >>> i;
			c_ang[i] = $signed({2'b00, sps_pkg::angle(i)});
		end
	end

	assign dv_r = dv_meta_s[16].zero ? 17'd0 :
		(dv_sat_s[16] ? sps_pkg::FACTOR_ONE : {1'b0, dv_quo_s[16]});
	assign th_prod = 48'(dv_r) * 48'(sps_pkg::PIHALF_Q30);

	assign sine = c_y_s[N][33] ? 31'd0 :
		((c_y_s[N] > 34'sd1073741824) ? 31'd1073741824 : c_y_s[N][30:0]);
	assign f_sum = {1'b0, sq_s1} + 63'h800_0000_0000;
	assign f_val = sq_meta_s1.zero ? 17'd0 :
		((f_sum[62:44] > 19'(sps_pkg::FACTOR_ONE)) ? sps_pkg::FACTOR_ONE : f_sum[60:44]);
	assign g_sum = 37'(f_s2) * 37'(rate) + 37'd32768;

	assign diff  = $signed({g_meta_s3.velocity[31], g_meta_s3.velocity})
		- $signed({reference[31], reference});
	assign e_d   = 22'd65536 + 22'(g_s3);
	assign e_mag = g_meta_s3.velocity[31] ? (32'd0 - g_meta_s3.velocity) : g_meta_s3.velocity;
	assign e_num = {e_mag, 16'd0} + 48'(e_d[21:1]);

	// Explicit relaxation, saturated to the 32-bit range.
	assign ex_delta = (e_prod_s4 + 55'sd32768) >>> 16;
	assign ex_res   = $signed({{24{q_meta_s[0].velocity[31]}}, q_meta_s[0].velocity})
		- $signed({ex_delta[54], ex_delta});
	assign ex_sat   = (ex_res > 56'sd2147483647) ? 32'h7fff_ffff :
		((ex_res < -56'sd2147483648) ? 32'h8000_0000 : ex_res[31:0]);

	assign imp_res = q_meta_s[32].velocity[31] ? (32'd0 - q_quo_s[32]) : q_quo_s[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= 16; k++) dv_vld_s[k] <= 1'b0;
			for (int i = 0; i <= N; i++) c_vld_s[i] <= 1'b0;
			for (int k = 0; k <= 32; k++) q_vld_s[k] <= 1'b0;
			sq_vld_s1 <= 1'b0;
			f_vld_s2  <= 1'b0;
			g_vld_s3  <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= item_valid;
			for (int k = 1; k <= 16; k++) dv_vld_s[k] <= dv_vld_s[k-1];
			c_vld_s[0] <= dv_vld_s[16];
			for (int i = 1; i <= N; i++) c_vld_s[i] <= c_vld_s[i-1];
			sq_vld_s1  <= c_vld_s[N];
			f_vld_s2   <= sq_vld_s1;
			g_vld_s3   <= f_vld_s2;
			q_vld_s[0] <= g_vld_s3;
			for (int k = 1; k <= 32; k++) q_vld_s[k] <= q_vld_s[k-1];
			out_vld_q <= q_vld_s[32];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_meta_s[0] <= '{velocity: item.velocity, bad: item.bad, zero: item.zero};
			dv_rem_s[0]  <= item.dz;
			dv_quo_s[0]  <= 16'd0;
			dv_dt_s[0]   <= item.dt;
			dv_sat_s[0]  <= item.sat;
			for (int k = 1; k <= 16; k++) begin
				dv_meta_s[k] <= dv_meta_s[k-1];
				dv_rem_s[k]  <= dv_ge[k] ? 24'(dv_sh[k] - {1'b0, dv_dt_s[k-1]}) : dv_sh[k][23:0];
				dv_quo_s[k]  <= {dv_quo_s[k-1][14:0], dv_ge[k]};
				dv_dt_s[k]   <= dv_dt_s[k-1];
				dv_sat_s[k]  <= dv_sat_s[k-1];
			end

			c_meta_s[0] <= dv_meta_s[16];
			c_x_s[0]    <= sps_pkg::CORDIC_GAIN_Q30;
			c_y_s[0]    <= 34'sd0;
			c_a_s[0]    <= $signed({2'b00, th_prod[47:16]});
			for (int i = 0; i < N; i++) begin
				c_meta_s[i+1] <= c_meta_s[i];
				if (c_a_s[i][33]) begin
					c_x_s[i+1] <= c_x_s[i] + c_ys[i];
					c_y_s[i+1] <= c_y_s[i] - c_xs[i];
					c_a_s[i+1] <= c_a_s[i] + c_ang[i];
				end else begin
					c_x_s[i+1] <= c_x_s[i] - c_ys[i];
					c_y_s[i+1] <= c_y_s[i] + c_xs[i];
					c_a_s[i+1] <= c_a_s[i] - c_ang[i];
				end
			end

			sq_meta_s1 <= c_meta_s[N];
			sq_s1      <= 62'(sine) * 62'(sine);
			f_meta_s2  <= sq_meta_s1;
			f_s2       <= f_val;
			g_meta_s3  <= f_meta_s2;
			g_f_s3     <= f_s2;
			g_s3       <= g_sum[36:16];

			q_meta_s[0] <= g_meta_s3;
			q_f_s[0]    <= g_f_s3;
			q_d_s[0]    <= e_d;
			q_rem_s[0]  <= 22'(e_num[47:32]);
			q_lo_s[0]   <= e_num[31:0];
			q_quo_s[0]  <= 32'd0;
			e_prod_s4   <= $signed({34'd0, g_s3}) * $signed({{22{diff[32]}}, diff});
			for (int k = 1; k <= 32; k++) begin
				q_meta_s[k] <= q_meta_s[k-1];
				q_f_s[k]    <= q_f_s[k-1];
				q_d_s[k]    <= q_d_s[k-1];
				q_rem_s[k]  <= q_ge[k] ? 22'(q_sh[k] - {1'b0, q_d_s[k-1]}) : q_sh[k][21:0];
				q_lo_s[k]   <= {q_lo_s[k-1][30:0], 1'b0};
				q_quo_s[k]  <= {q_quo_s[k-1][30:0], q_ge[k]};
			end
			q_res_s[1] <= ex_sat;
			for (int k = 2; k <= 32; k++) q_res_s[k] <= q_res_s[k-1];

			out_v_q   <= implicit_mode ? imp_res : q_res_s[32];
			out_f_q   <= q_f_s[32];
			out_bad_q <= q_meta_s[32].bad;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.velocity_out   = out_v_q;
	assign result.damping_factor = out_f_q;
	assign result.bad_column     = out_bad_q;
endmodule
`default_nettype wire

FILE: sv/rayleigh_sponge_damping.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Payload
// point    | in  | point_height[23:0], top_height[23:0], velocity_in[31:0]
// result   | out | velocity_out[31:0], damping_factor[16:0], bad_column
// cfg      | in  | index[1:0], data[31:0]; always ready
//
// One point per cycle, sustained while the result side accepts. A point passes
// the front register, the queue, the 16-step ratio divider, the CORDIC stages,
// the square, factor and gain stages, the 32-step implicit divider and the
// output register, all fully pipelined.
// Reset clears all valid bits, the queue and the configuration registers.
// A stalled result holds the whole back pipeline; the front keeps filling a
// four-entry queue and stops taking points once the queue and its own register
// are both full.
module rayleigh_sponge_damping #(
	parameter int unsigned SINE_ITERATIONS = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	sps_in_if.sink    point,
	sps_out_if.source result,
	sps_cfg_if.sink   cfg
);
	logic [23:0]    start_q;
	logic [19:0]    rate_q;
	logic [31:0]    ref_q;
	logic           implicit_q;
	sps_pkg::item_t f_item;
	logic           f_valid;
	logic           f_ready;
	sps_pkg::item_t b_item;
	logic           b_valid;
	logic           b_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= 24'd0;
			rate_q     <= 20'd0;
			ref_q      <= 32'd0;
			implicit_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				sps_pkg::REG_SPONGE_START: start_q    <= cfg.data[23:0];
				sps_pkg::REG_DAMPING_RATE: rate_q     <= cfg.data[19:0];
				sps_pkg::REG_REFERENCE:    ref_q      <= cfg.data;
				sps_pkg::REG_IMPLICIT:     implicit_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	sps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.point        (point),
		.start_height (start_q),
		.item         (f_item),
		.item_valid   (f_valid),
		.item_ready   (f_ready)
	);

	sps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_item   (b_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	sps_back #(
		.SINE_ITERATIONS (SINE_ITERATIONS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (b_item),
		.item_valid    (b_valid),
		.item_ready    (b_ready),
		.rate          (rate_q),
		.reference     (ref_q),
		.implicit_mode (implicit_q),
		.result        (result)
	);
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam longint ATAN_Q30 [24] = '{
		843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437,
		4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048,
		1024, 512, 256, 128
	};

	typedef struct {
		logic [31:0] velocity;
		logic [16:0] factor;
		logic        bad;
	} damped_t;

	typedef struct {
		logic [23:0] height;
		logic [23:0] top;
		logic [31:0] velocity;
		bit          known;
		damped_t     want;
	} point_row_t;

	logic clk;
	logic arst_n;

	sps_in_if  point();
	sps_out_if result();
	sps_cfg_if cfg();

	rayleigh_sponge_damping #(.SINE_ITERATIONS(CORDIC_STEPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	// Shadow copy of the configuration registers.
	logic [23:0] start_height;
	logic [19:0] rate_q16;
	logic [31:0] relax_target;
	logic        implicit_on;

	damped_t damped_q[$];
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit idle_on;
	bit hold_request;

	point_row_t directed_rows [10] = '{
		'{24'h000000, 24'h000000, 32'h00000000, 1'b1, '{32'h00000000, 17'd0, 1'b1}},
		'{24'hFFFFFF, 24'h000000, 32'h7FFFFFFF, 1'b1, '{32'h7FFFFFFF, 17'd0, 1'b1}},
		'{24'h000000, 24'hFFFFFF, 32'h80000000, 1'b1, '{32'h80000000, 17'd0, 1'b0}},
		'{24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 1'b0, '{32'h0, 17'd0, 1'b0}},
		'{24'h800000, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, '{32'h0, 17'd0, 1'b0}},
		'{24'hFFFFFF, 24'h000001, 32'h80000000, 1'b0, '{32'h0, 17'd0, 1'b0}},
		'{24'h000001, 24'hFFFFFF, 32'h00000001, 1'b0, '{32'h0, 17'd0, 1'b0}},
		'{24'hC00000, 24'hFFFFFF, 32'h12345678, 1'b0, '{32'h0, 17'd0, 1'b0}},
		'{24'hAAAAAA, 24'h555555, 32'h55555555, 1'b0, '{32'h0, 17'd0, 1'b0}},
		'{24'h955555, 24'hAAAAAA, 32'hAAAAAAAA, 1'b0, '{32'h0, 17'd0, 1'b0}}
	};

	function automatic logic [16:0] sine_squared(longint ratio);
		longint theta, x, y, angle_left, xs, ys;
		theta = (ratio * longint'(sps_pkg::PIHALF_Q30)) >>> 16;
		x = longint'(sps_pkg::CORDIC_GAIN_Q30);
		y = 0;
		angle_left = theta;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (angle_left >= 0) begin
				x = x - ys;
				y = y + xs;
				angle_left = angle_left - ATAN_Q30[i];
			end else begin
				x = x + ys;
				y = y - xs;
				angle_left = angle_left + ATAN_Q30[i];
			end
		end
		if (y < 0)
			y = 0;
		if (y > (longint'(1) << 30))
			y = longint'(1) << 30;
		y = (y * y + (longint'(1) << 43)) >>> 44;
		if (y > 65536)
			y = 65536;
		return y[16:0];
	endfunction

	function automatic damped_t damp_point(logic [23:0] height, logic [23:0] top,
			logic [31:0] velocity);
		damped_t res;
		longint v, ratio, gain, denom, mag, quot, outv;
		v = longint'($signed(velocity));
		res.factor = '0;
		res.bad = 1'b0;
		if (top <= start_height) begin
			res.bad = 1'b1;
		end else if (height > start_height) begin
			ratio = (longint'(height - start_height) << 16) / longint'(top - start_height);
			if (ratio > 65536)
				ratio = 65536;
			res.factor = sine_squared(ratio);
		end
		gain = (longint'(res.factor) * longint'(rate_q16) + 32768) >>> 16;
		if (implicit_on) begin
			denom = 65536 + gain;
			mag = (v < 0 ? -v : v) << 16;
			quot = (mag + denom / 2) / denom;
			outv = v < 0 ? -quot : quot;
		end else begin
			outv = v - ((gain * (v - longint'($signed(relax_target))) + 32768) >>> 16);
			if (outv > 64'sd2147483647)
				outv = 64'sd2147483647;
			if (outv < -64'sd2147483648)
				outv = -64'sd2147483648;
		end
		res.velocity = outv[31:0];
		return res;
	endfunction

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: any accepted beat on any channel resets the count.
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("rayleigh_sponge_damping test failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold on request.
	initial begin
		int unsigned wait_left;
		damped_t want;
		wait_left = 0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (damped_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: v=%h f=%0d bad=%b",
							result.velocity_out, result.damping_factor,
							result.bad_column);
				end else begin
					want = damped_q.pop_front();
					if (result.velocity_out !== want.velocity
							|| result.damping_factor !== want.factor
							|| result.bad_column !== want.bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp v=%h f=%0d bad=%b got v=%h f=%0d bad=%b",
								want.velocity, want.factor, want.bad,
								result.velocity_out, result.damping_factor,
								result.bad_column);
					end
				end
				wait_left = idle_on ? $urandom_range(0, 15) : 0;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				wait_left = HOLD_CYCLES;
			end
			if (wait_left > 0) begin
				result.ready <= 1'b0;
				wait_left--;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Leaves valid high so that consecutive writes go out back to back.
	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		cfg.index <= index;
		cfg.data <= data;
		cfg.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (index)
			sps_pkg::REG_SPONGE_START: start_height = data[23:0];
			sps_pkg::REG_DAMPING_RATE: rate_q16 = data[19:0];
			sps_pkg::REG_REFERENCE:    relax_target = data;
			sps_pkg::REG_IMPLICIT:     implicit_on = data[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [23:0] zs, logic [19:0] rate, logic [31:0] target,
			logic mode);
		wait (damped_q.size() == 0);
		@(posedge clk);
		write_reg(sps_pkg::REG_SPONGE_START, {8'h00, zs});
		write_reg(sps_pkg::REG_DAMPING_RATE, {12'h000, rate});
		write_reg(sps_pkg::REG_REFERENCE, target);
		write_reg(sps_pkg::REG_IMPLICIT, {31'd0, mode});
		cfg.valid <= 1'b0;
	endtask

	// Offers one point, keeping valid high across back-to-back beats.
	task automatic send_point(point_row_t row, bit use_typed);
		int unsigned gap;
		point.point_height <= row.height;
		point.top_height <= row.top;
		point.velocity_in <= row.velocity;
		point.valid <= 1'b1;
		do
			@(posedge clk);
		while (!point.ready);
		if (use_typed && row.known)
			damped_q.push_back(row.want);
		else
			damped_q.push_back(damp_point(row.height, row.top, row.velocity));
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			point.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic point_row_t random_point();
		point_row_t row;
		int unsigned span, pick;
		row.known = 1'b0;
		row.want = '{32'h0, 17'd0, 1'b0};
		pick = $urandom_range(0, 9);
		row.velocity = (pick < 5) ? $urandom() : 32'($signed($urandom_range(0, 1 << 22))
			- (1 << 21));
		if (pick < 2 || start_height == 24'hFFFFFF) begin
			row.height = 24'($urandom());
			row.top = 24'($urandom());
		end else begin
			span = $urandom_range(1, 24'hFFFFFF - start_height);
			if ($urandom_range(0, 3) == 0)
				span = $urandom_range(1, span < 64 ? span : 64);
			row.top = 24'(start_height + span);
			pick = $urandom_range(0, span + span / 4);
			if ($urandom_range(0, 7) == 0)
				row.height = 24'($urandom_range(0, start_height));
			else if (start_height + pick > 24'hFFFFFF)
				row.height = 24'hFFFFFF;
			else
				row.height = 24'(start_height + pick);
		end
		return row;
	endfunction

	initial begin
		logic [23:0] zs;
		logic [19:0] rate;
		logic [31:0] target;
		arst_n = 1'b0;
		point.valid = 1'b0;
		point.point_height = '0;
		point.top_height = '0;
		point.velocity_in = '0;
		cfg.valid = 1'b0;
		cfg.index = sps_pkg::REG_SPONGE_START;
		cfg.data = '0;
		start_height = '0;
		rate_q16 = '0;
		relax_target = '0;
		implicit_on = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: zero rate, so the velocity passes through.
		foreach (directed_rows[i])
			send_point(directed_rows[i], 1'b1);
		point.valid <= 1'b0;
		// Full rate toward the most negative target drives explicit overflow.
		configure(24'h800000, 20'hFFFFF, 32'h80000000, 1'b0);
		foreach (directed_rows[i])
			send_point(directed_rows[i], 1'b0);
		point.valid <= 1'b0;
		configure(24'hFFFFFF, 20'hFFFFF, 32'h7FFFFFFF, 1'b1);
		foreach (directed_rows[i])
			send_point(directed_rows[i], 1'b0);
		point.valid <= 1'b0;

		for (int phase = 0; phase < 7; phase++) begin
			zs = (phase % 3 == 0) ? 24'h000000 : 24'($urandom_range(0, 24'hF00000));
			rate = (phase == 1) ? 20'hFFFFF : 20'($urandom());
			target = (phase == 4) ? 32'h7FFFFFFF : $urandom();
			configure(zs, rate, target, phase[0]);
			idle_on = (phase != 2);
			if (phase == 2)
				hold_request = 1'b1;
			for (int n = 0; n < 100; n++)
				send_point(random_point(), 1'b0);
			point.valid <= 1'b0;
		end

		wait (damped_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && damped_q.size() == 0)
			$display("rayleigh_sponge_damping test passed");
		else
			$display("rayleigh_sponge_damping test failed");
		$finish;
	end
endmodule

FILE: filelist.f
sv/sps_pkg.sv
sv/sps_if.sv
sv/sps_front.sv
sv/sps_queue.sv
sv/sps_back.sv
sv/rayleigh_sponge_damping.sv
tb/tb_top.sv
